FILE: design/dnsap_pkg.sv
package dnsap_pkg;

    localparam int MaxPacketBytes = 512;
    localparam int HeaderLen      = 12;

    localparam int FifoDepth = 4;
    localparam int FifoPtrW  = $clog2(FifoDepth);
    localparam int FifoCntW  = $clog2(FifoDepth + 1);

    // output tdata: fields packed low to high, padded to whole bytes
    localparam int OutFieldBits = 16 + 16 + 32 + 16 + 32 + 3 + 16;
    localparam int OutDataW     = ((OutFieldBits + 7) / 8) * 8;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StShort    = 3'd1;
    localparam logic [2:0] StIdMis    = 3'd2;
    localparam logic [2:0] StRcode    = 3'd3;
    localparam logic [2:0] StOversize = 3'd4;

    // one queue entry: a finished record, a summary, or both (record first)
    typedef struct packed {
        logic        has_rec;
        logic        has_sum;
        logic [15:0] rec_type;
        logic [15:0] rec_class;
        logic [31:0] ttl;
        logic [15:0] data_len;
        logic [31:0] data_head;
        logic [2:0]  status;
        logic [15:0] answer_count;
    } t_event;

endpackage

FILE: design/dnsap_front.sv
module dnsap_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_accept,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_push,
    output dnsap_pkg::t_event     o_event
);

    localparam logic [3:0] PhHeader = 4'd0;
    localparam logic [3:0] PhQname  = 4'd1;
    localparam logic [3:0] PhQptr   = 4'd2;
    localparam logic [3:0] PhQlabel = 4'd3;
    localparam logic [3:0] PhQfixed = 4'd4;
    localparam logic [3:0] PhAname  = 4'd5;
    localparam logic [3:0] PhAptr   = 4'd6;
    localparam logic [3:0] PhAlabel = 4'd7;
    localparam logic [3:0] PhAfixed = 4'd8;
    localparam logic [3:0] PhAdata  = 4'd9;
    localparam logic [3:0] PhDone   = 4'd10;

    logic [15:0] r_match_id;
    logic [3:0]  r_phase,      n_phase;
    logic [15:0] r_byte_count, n_byte_count;
    logic [15:0] r_ident,      n_ident;
    logic [3:0]  r_rcode,      n_rcode;
    logic [15:0] r_qleft,      n_qleft;
    logic [15:0] r_aleft,      n_aleft;
    logic [15:0] r_skip,       n_skip;
    logic [3:0]  r_fidx,       n_fidx;
    logic [15:0] r_type,       n_type;
    logic [15:0] r_class,      n_class;
    logic [31:0] r_ttl,        n_ttl;
    logic [15:0] r_len,        n_len;
    logic [31:0] r_head,       n_head;
    logic [15:0] r_found,      n_found;
    logic        r_oversize,   n_oversize;

    logic        byte_ok;
    logic        rec_fire;
    logic        sum_fire;
    logic [15:0] len_done;
    logic [15:0] pos;
    logic [15:0] aleft_dec;
    logic [15:0] qleft_dec;
    logic [2:0]  sum_status;

    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_ident      = r_ident;
        n_rcode      = r_rcode;
        n_qleft      = r_qleft;
        n_aleft      = r_aleft;
        n_skip       = r_skip;
        n_fidx       = r_fidx;
        n_type       = r_type;
        n_class      = r_class;
        n_ttl        = r_ttl;
        n_len        = r_len;
        n_head       = r_head;
        n_found      = r_found;
        n_oversize   = r_oversize;
        rec_fire     = 1'b0;
        sum_fire     = 1'b0;
        sum_status   = dnsap_pkg::StOk;

        byte_ok   = i_accept && (r_byte_count < 16'(dnsap_pkg::MaxPacketBytes));
        len_done  = {r_len[15:8], i_byte};
        pos       = r_len - r_skip;
        aleft_dec = r_aleft - 16'd1;
        qleft_dec = r_qleft - 16'd1;

        if (i_accept && !byte_ok) begin
            n_oversize = 1'b1;
        end

        if (byte_ok) begin
            n_byte_count = r_byte_count + 16'd1;
            case (r_phase)
                PhHeader: begin
                    case (r_byte_count[3:0])
                        4'd0:    n_ident = {i_byte, 8'h00};
                        4'd1:    n_ident = {r_ident[15:8], i_byte};
                        4'd3:    n_rcode = i_byte[3:0];
                        4'd4:    n_qleft = {i_byte, 8'h00};
                        4'd5:    n_qleft = {r_qleft[15:8], i_byte};
                        4'd6:    n_aleft = {i_byte, 8'h00};
                        4'd7:    n_aleft = {r_aleft[15:8], i_byte};
                        4'd11: begin
                            if (r_ident != r_match_id || r_rcode != 4'd0) begin
                                n_phase = PhDone;
                            end else if (r_qleft != 16'd0) begin
                                n_phase = PhQname;
                            end else if (r_aleft != 16'd0) begin
                                n_phase = PhAname;
                            end else begin
                                n_phase = PhDone;
                            end
                        end
                        default: ;
                    endcase
                end
                PhQname, PhAname: begin
                    if (i_byte == 8'h00) begin
                        n_phase = (r_phase == PhQname) ? PhQfixed : PhAfixed;
                        n_fidx  = 4'd0;
                    end else if (i_byte[7:6] == 2'b11) begin
                        n_phase = (r_phase == PhQname) ? PhQptr : PhAptr;
                    end else begin
                        n_skip  = {8'h00, i_byte};
                        n_phase = (r_phase == PhQname) ? PhQlabel : PhAlabel;
                    end
                end
                PhQptr: begin
                    n_phase = PhQfixed;
                    n_fidx  = 4'd0;
                end
                PhAptr: begin
                    n_phase = PhAfixed;
                    n_fidx  = 4'd0;
                end
                PhQlabel: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = PhQname;
                    end
                end
                PhAlabel: begin
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        n_phase = PhAname;
                    end
                end
                PhQfixed: begin
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx >= 4'd3) begin
                        n_qleft = qleft_dec;
                        if (qleft_dec != 16'd0) begin
                            n_phase = PhQname;
                        end else if (r_aleft != 16'd0) begin
                            n_phase = PhAname;
                        end else begin
                            n_phase = PhDone;
                        end
                    end
                end
                PhAfixed: begin
                    case (r_fidx)
                        4'd0:    n_type  = {i_byte, 8'h00};
                        4'd1:    n_type  = {r_type[15:8], i_byte};
                        4'd2:    n_class = {i_byte, 8'h00};
                        4'd3:    n_class = {r_class[15:8], i_byte};
                        4'd4:    n_ttl   = {i_byte, 24'h000000};
                        4'd5:    n_ttl   = {r_ttl[31:24], i_byte, 16'h0000};
                        4'd6:    n_ttl   = {r_ttl[31:16], i_byte, 8'h00};
                        4'd7:    n_ttl   = {r_ttl[31:8], i_byte};
                        4'd8:    n_len   = {i_byte, 8'h00};
                        default: n_len   = len_done;
                    endcase
                    n_fidx = r_fidx + 4'd1;
                    if (r_fidx >= 4'd9) begin
                        n_head = 32'h0;
                        if (len_done == 16'd0) begin
                            rec_fire = 1'b1;
                            n_aleft  = aleft_dec;
                            n_found  = r_found + 16'd1;
                            n_phase  = (aleft_dec != 16'd0) ? PhAname : PhDone;
                        end else begin
                            n_skip  = len_done;
                            n_phase = PhAdata;
                        end
                    end
                end
                PhAdata: begin
                    if (pos[15:2] == 14'd0) begin
                        case (pos[1:0])
                            2'd0:    n_head[31:24] = i_byte;
                            2'd1:    n_head[23:16] = i_byte;
                            2'd2:    n_head[15:8]  = i_byte;
                            default: n_head[7:0]   = i_byte;
                        endcase
                    end
                    n_skip = r_skip - 16'd1;
                    if (r_skip == 16'd1) begin
                        rec_fire = 1'b1;
                        n_aleft  = aleft_dec;
                        n_found  = r_found + 16'd1;
                        n_phase  = (aleft_dec != 16'd0) ? PhAname : PhDone;
                    end
                end
                default: ;
            endcase
        end

        // summary judged on the state including this byte
        if (n_byte_count < 16'(dnsap_pkg::HeaderLen)) begin
            sum_status = dnsap_pkg::StShort;
        end else if (n_ident != r_match_id) begin
            sum_status = dnsap_pkg::StIdMis;
        end else if (n_rcode != 4'd0) begin
            sum_status = dnsap_pkg::StRcode;
        end else if (n_oversize) begin
            sum_status = dnsap_pkg::StOversize;
        end

        o_event.has_rec      = rec_fire;
        o_event.has_sum      = sum_fire;
        o_event.rec_type     = n_type;
        o_event.rec_class    = n_class;
        o_event.ttl          = n_ttl;
        o_event.data_len     = n_len;
        o_event.data_head    = n_head;
        o_event.status       = sum_status;
        o_event.answer_count = n_found;

        if (i_accept && i_last) begin
            sum_fire        = 1'b1;
            o_event.has_sum = 1'b1;
            n_phase         = PhHeader;
            n_byte_count    = 16'd0;
            n_found         = 16'd0;
            n_oversize      = 1'b0;
        end
        o_push = rec_fire || sum_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_id    <= 16'd0;
            r_phase       <= PhHeader;
            r_byte_count  <= 16'd0;
            r_ident       <= 16'd0;
            r_rcode       <= 4'd0;
            r_qleft       <= 16'd0;
            r_aleft       <= 16'd0;
            r_skip        <= 16'd0;
            r_fidx        <= 4'd0;
            r_found       <= 16'd0;
            r_oversize    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_match_id <= i_cfg_wdata;
            end
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_ident      <= n_ident;
            r_rcode      <= n_rcode;
            r_qleft      <= n_qleft;
            r_aleft      <= n_aleft;
            r_skip       <= n_skip;
            r_fidx       <= n_fidx;
            r_found      <= n_found;
            r_oversize   <= n_oversize;
        end
    end

    // record fields are always written before they are emitted
    always_ff @(posedge i_clk) begin
        r_type  <= n_type;
        r_class <= n_class;
        r_ttl   <= n_ttl;
        r_len   <= n_len;
        r_head  <= n_head;
    end

endmodule

FILE: design/dnsap_fifo.sv
module dnsap_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  dnsap_pkg::t_event                   i_event,
    input  logic                                i_pop,
    output dnsap_pkg::t_event                   o_head,
    output logic                                o_empty,
    output logic                                o_full,
    output logic [dnsap_pkg::FifoCntW-1:0]      o_count
);

    dnsap_pkg::t_event                 r_mem [dnsap_pkg::FifoDepth];
    logic [dnsap_pkg::FifoPtrW-1:0]    r_wr_ptr;
    logic [dnsap_pkg::FifoPtrW-1:0]    r_rd_ptr;
    logic [dnsap_pkg::FifoCntW-1:0]    r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == dnsap_pkg::FifoCntW'(dnsap_pkg::FifoDepth));
    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_event;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/dnsap_back.sv
module dnsap_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dnsap_pkg::t_event                 i_head,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [dnsap_pkg::OutDataW-1:0]    o_tdata,
    output logic                              o_tuser,
    output logic                              o_tlast
);

    localparam int PadW = dnsap_pkg::OutDataW - dnsap_pkg::OutFieldBits;

    logic                              r_valid;
    logic [dnsap_pkg::OutDataW-1:0]    r_data;
    logic                              r_kind;
    logic                              r_done;
    logic                              r_rec_sent;
    logic                              load;
    logic                              send_rec;

    assign load     = !r_valid || i_tready;
    assign send_rec = i_head.has_rec && !r_rec_sent;
    // an entry leaves once its last part is loaded
    assign o_pop    = load && !i_empty && !(send_rec && i_head.has_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_rec_sent <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_rec_sent <= send_rec && i_head.has_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            if (send_rec) begin
                r_kind <= 1'b0;
                r_done <= 1'b0;
                r_data <= {PadW'(0), i_head.answer_count, dnsap_pkg::StOk,
                           i_head.data_head, i_head.data_len, i_head.ttl,
                           i_head.rec_class, i_head.rec_type};
            end else begin
                r_kind <= 1'b1;
                r_done <= 1'b1;
                r_data <= {PadW'(0), i_head.answer_count, i_head.status,
                           32'h0, 16'h0, 32'h0, 16'h0, 16'h0};
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_kind;
    assign o_tlast  = r_done;

endmodule

FILE: design/dns_response_answer_parser_unit.sv
// A result is written into a 4-entry queue when the byte that causes it is accepted,
// and is then loaded into the m_axis output register. Throughput: one byte per cycle;
// a byte that ends both a record and the packet yields one queue entry that is sent
// as two results, record first. Input stalls only when that queue is full.
// Reset (synchronous, active low) returns the parser to the header phase, empties
// the queue and the output register, and clears the configured identifier to zero.
module dns_response_answer_parser_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [15:0]                       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // data_byte
    input  logic                              s_axis_tlast,  // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rec_type[15:0] rec_class[31:16] time_to_live[63:32] data_length[79:64]
    // data_head[111:80] status[114:112] answer_count[130:115] zero pad[135:131]
    output logic [dnsap_pkg::OutDataW-1:0]    m_axis_tdata,
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast   // packet_done
);

    logic                              accept;
    logic                              push;
    logic                              pop;
    logic                              fifo_empty;
    logic                              fifo_full;
    logic [dnsap_pkg::FifoCntW-1:0]    fifo_count;
    dnsap_pkg::t_event                 front_event;
    dnsap_pkg::t_event                 head_event;

    assign s_axis_tready = !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dnsap_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_push      (push),
        .o_event     (front_event)
    );

    dnsap_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_event (front_event),
        .i_pop   (pop),
        .o_head  (head_event),
        .o_empty (fifo_empty),
        .o_full  (fifo_full),
        .o_count (fifo_count)
    );

    dnsap_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_event),
        .i_empty  (fifo_empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_count == dnsap_pkg::FifoCntW'(dnsap_pkg::FifoDepth)) |-> !s_axis_tready)
        else $error("input accepted while result queue full");

    a_last_is_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("packet_done on a non-summary result");

    a_record_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[114:112] == dnsap_pkg::StOk))
        else $error("record result carries nonzero status");

    a_push_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> accept)
        else $error("queue written without an accepted byte");
`endif

endmodule

FILE: sim/tb_dns_response_answer_parser_unit.sv
`timescale 1ns / 1ps

module tb_dns_response_answer_parser_unit;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [15:0]                    i_cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata = '0;   // data_byte
    logic                           s_axis_tlast = 1'b0; // last_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // rec_type, rec_class, time_to_live, data_length, data_head, status, answer_count
    logic [dnsap_pkg::OutDataW-1:0] m_axis_tdata;
    logic                           m_axis_tuser;        // kind
    logic                           m_axis_tlast;        // packet_done

    dns_response_answer_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("tb_dns_response_answer_parser_unit: done, errors");
        $finish;
    end

    typedef struct packed {
        logic        kind;
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [31:0] ttl;
        logic [15:0] dlen;
        logic [31:0] head;
        logic [2:0]  status;
        logic [15:0] count;
        logic        done;
    } t_parse_result;

    typedef enum logic [3:0] {
        SEC_HEADER, SEC_QNAME, SEC_QPTR, SEC_QLABEL, SEC_QFIXED,
        SEC_ANAME, SEC_APTR, SEC_ALABEL, SEC_AFIXED, SEC_ADATA, SEC_DONE
    } t_section;

    typedef enum logic [2:0] {
        NAME_RANDOM, NAME_ROOT, NAME_PTR, NAME_LABELS, NAME_BIGLABEL
    } t_name_form;

    typedef enum logic [3:0] {
        DK_SHORT, DK_SHORT11, DK_EMPTY, DK_BADID, DK_RCODE, DK_BOTH,
        DK_PTR, DK_LABELS, DK_PAD, DK_TRUNC, DK_MIDID, DK_OVER
    } t_dcase;

    typedef struct packed {
        logic        cfg_we;
        logic [15:0] cfg_val;
        t_dcase      what;
        logic        typed;
        logic [2:0]  st;
        logic [15:0] cnt;
    } t_drow;

    t_parse_result due[$];
    int            errors = 0;
    int            bytes_sent = 0;
    bit            calm = 1'b0;

    // typed summary for directed rows that need no model
    bit            typed_on = 1'b0;
    logic [2:0]    typed_st;
    logic [15:0]   typed_cnt;

    // parser state mirror
    logic [15:0]   cur_id = '0;
    t_section      sec = SEC_HEADER;
    logic [15:0]   nbytes, hdr_id, q_left, a_left, skip, r_type, r_class, r_len, found;
    logic [3:0]    rcode, fidx;
    logic [31:0]   r_ttl, r_head;
    logic          over;

    logic [7:0]    pkt[$];
    int            split_at = -1;
    logic [15:0]   split_id;

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        pkt = {pkt, b};
    endtask

    task automatic restart_packet();
        sec = SEC_HEADER;
        nbytes = '0; hdr_id = '0; q_left = '0; a_left = '0; skip = '0;
        r_type = '0; r_class = '0; r_len = '0; found = '0;
        rcode = '0; fidx = '0; r_ttl = '0; r_head = '0; over = 1'b0;
    endtask

    task automatic finish_answer();
        t_parse_result r;
        a_left = a_left - 1;
        found = found + 1;
        r = '0;
        r.rtype = r_type;
        r.rclass = r_class;
        r.ttl = r_ttl;
        r.dlen = r_len;
        r.head = r_head;
        r.count = found;
        due = {due, r};
        sec = (a_left != 0) ? SEC_ANAME : SEC_DONE;
    endtask

    task automatic name_step(input logic [7:0] b, input bit ans);
        if (b == 8'h00) begin
            sec = ans ? SEC_AFIXED : SEC_QFIXED;
            fidx = '0;
        end else if (b[7:6] == 2'b11) begin
            sec = ans ? SEC_APTR : SEC_QPTR;
        end else begin
            skip = {8'h00, b};
            sec = ans ? SEC_ALABEL : SEC_QLABEL;
        end
    endtask

    // advances the mirror by one accepted byte, queueing what it yields
    task automatic track_byte(input logic [7:0] b, input logic lst);
        t_parse_result r;
        logic [15:0]   idx;
        int            p;
        if (nbytes >= dnsap_pkg::MaxPacketBytes) begin
            over = 1'b1;
        end else begin
            idx = nbytes;
            nbytes = nbytes + 1;
            case (sec)
                SEC_HEADER: begin
                    case (idx)
                        0: hdr_id = {b, 8'h00};
                        1: hdr_id[7:0] = b;
                        3: rcode = b[3:0];
                        4: q_left = {b, 8'h00};
                        5: q_left[7:0] = b;
                        6: a_left = {b, 8'h00};
                        7: a_left[7:0] = b;
                        default: ;
                    endcase
                    if (idx == dnsap_pkg::HeaderLen - 1) begin
                        if (hdr_id != cur_id || rcode != 0) sec = SEC_DONE;
                        else if (q_left != 0) sec = SEC_QNAME;
                        else sec = (a_left != 0) ? SEC_ANAME : SEC_DONE;
                    end
                end
                SEC_QNAME: name_step(b, 1'b0);
                SEC_QPTR: begin
                    sec = SEC_QFIXED;
                    fidx = '0;
                end
                SEC_QLABEL: begin
                    skip = skip - 1;
                    if (skip == 0) sec = SEC_QNAME;
                end
                SEC_QFIXED: begin
                    fidx = fidx + 1;
                    if (fidx >= 4) begin
                        q_left = q_left - 1;
                        if (q_left != 0) sec = SEC_QNAME;
                        else sec = (a_left != 0) ? SEC_ANAME : SEC_DONE;
                    end
                end
                SEC_ANAME: name_step(b, 1'b1);
                SEC_APTR: begin
                    sec = SEC_AFIXED;
                    fidx = '0;
                end
                SEC_ALABEL: begin
                    skip = skip - 1;
                    if (skip == 0) sec = SEC_ANAME;
                end
                SEC_AFIXED: begin
                    case (fidx)
                        0: r_type = {b, 8'h00};
                        1: r_type[7:0] = b;
                        2: r_class = {b, 8'h00};
                        3: r_class[7:0] = b;
                        4: r_ttl = {b, 24'h000000};
                        5: r_ttl[23:16] = b;
                        6: r_ttl[15:8] = b;
                        7: r_ttl[7:0] = b;
                        8: r_len = {b, 8'h00};
                        default: r_len[7:0] = b;
                    endcase
                    fidx = fidx + 1;
                    if (fidx >= 10) begin
                        r_head = '0;
                        if (r_len == 0) begin
                            finish_answer();
                        end else begin
                            skip = r_len;
                            sec = SEC_ADATA;
                        end
                    end
                end
                SEC_ADATA: begin
                    p = int'(r_len - skip);
                    if (p < 4) r_head[8*(3-p) +: 8] = b;
                    skip = skip - 1;
                    if (skip == 0) finish_answer();
                end
                default: ;
            endcase
        end
        if (lst) begin
            r = '0;
            r.kind = 1'b1;
            r.done = 1'b1;
            r.count = found;
            if (nbytes < dnsap_pkg::HeaderLen) r.status = dnsap_pkg::StShort;
            else if (hdr_id != cur_id) r.status = dnsap_pkg::StIdMis;
            else if (rcode != 0) r.status = dnsap_pkg::StRcode;
            else if (over) r.status = dnsap_pkg::StOversize;
            else r.status = dnsap_pkg::StOk;
            if (typed_on) begin
                r.status = typed_st;
                r.count = typed_cnt;
            end
            due = {due, r};
            restart_packet();
        end
    endtask

    // ---------------- packet building ----------------

    task automatic add_header(input logic [15:0] id, input logic [7:0] b3,
                              input logic [15:0] qd, input logic [15:0] an);
        put_byte(id[15:8]);
        put_byte(id[7:0]);
        put_byte(rnd8());
        put_byte(b3);
        put_byte(qd[15:8]);
        put_byte(qd[7:0]);
        put_byte(an[15:8]);
        put_byte(an[7:0]);
        repeat (4) put_byte(rnd8());
    endtask

    task automatic add_name(input t_name_form f);
        t_name_form g;
        int         r, n, len;
        g = f;
        if (g == NAME_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 30) g = NAME_PTR;
            else if (r < 45) g = NAME_ROOT;
            else if (r < 98) g = NAME_LABELS;
            else g = NAME_BIGLABEL;
        end
        case (g)
            NAME_ROOT: put_byte(8'h00);
            NAME_PTR: begin
                put_byte(8'hC0 | 8'($urandom_range(0, 63)));
                put_byte(rnd8());
            end
            NAME_BIGLABEL: begin
                put_byte(8'd191);
                repeat (191) put_byte(rnd8());
                put_byte(8'd1);
                put_byte(rnd8());
                put_byte(8'h00);
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) begin
                    len = $urandom_range(1, 10);
                    put_byte(8'(len));
                    repeat (len) put_byte(rnd8());
                end
                // labels may end in a pointer instead of the root
                if ($urandom_range(0, 3) == 0) begin
                    put_byte(8'hC0 | 8'($urandom_range(0, 63)));
                    put_byte(rnd8());
                end else begin
                    put_byte(8'h00);
                end
            end
        endcase
    endtask

    task automatic add_rr(input logic [15:0] t, input logic [15:0] c,
                          input logic [31:0] ttl, input logic [15:0] len);
        put_byte(t[15:8]);
        put_byte(t[7:0]);
        put_byte(c[15:8]);
        put_byte(c[7:0]);
        put_byte(ttl[31:24]);
        put_byte(ttl[23:16]);
        put_byte(ttl[15:8]);
        put_byte(ttl[7:0]);
        put_byte(len[15:8]);
        put_byte(len[7:0]);
        repeat (int'(len)) put_byte(rnd8());
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 80) return 16'($urandom_range(1, 8));
        return 16'($urandom_range(9, 40));
    endfunction

    task automatic add_body(input int nq, input int na);
        repeat (nq) begin
            add_name(NAME_RANDOM);
            repeat (4) put_byte(rnd8());
        end
        repeat (na) begin
            add_name(NAME_RANDOM);
            add_rr(16'($urandom), 16'($urandom), $urandom, pick_len());
        end
    endtask

    task automatic cut_to(input int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endtask

    task automatic pad_to(input int n);
        while (pkt.size() < n) put_byte(rnd8());
    endtask

    task automatic build_directed(input t_dcase what);
        pkt.delete();
        split_at = -1;
        case (what)
            DK_SHORT: put_byte(8'hFF);
            DK_SHORT11: repeat (11) put_byte(8'h00);
            DK_EMPTY: add_header(cur_id, 8'h80, 16'd0, 16'd0);
            DK_BADID: begin
                add_header(cur_id ^ 16'hFFFF, 8'h00, 16'd0, 16'd1);
                add_name(NAME_ROOT);
                add_rr(16'd1, 16'd1, 32'd60, 16'd0);
            end
            DK_RCODE: begin
                add_header(cur_id, 8'hFF, 16'd0, 16'd1);
                add_name(NAME_ROOT);
                add_rr(16'd1, 16'd1, 32'd60, 16'd0);
            end
            DK_BOTH: add_header(cur_id ^ 16'h0100, 8'h01, 16'd0, 16'd0);
            DK_PTR: begin
                add_header(cur_id, 8'h80, 16'd1, 16'd1);
                add_name(NAME_PTR);
                repeat (4) put_byte(8'hFF);
                put_byte(8'hFF);
                put_byte(8'hFF);
                add_rr(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
                put_byte(8'h00);
            end
            DK_LABELS: begin
                // record completes on the final byte: record, then summary
                add_header(cur_id, 8'h00, 16'd1, 16'd1);
                add_name(NAME_LABELS);
                repeat (4) put_byte(8'h00);
                add_name(NAME_LABELS);
                add_rr(16'h0000, 16'h0000, 32'h0, 16'd4);
            end
            DK_PAD: begin
                add_header(cur_id, 8'h00, 16'd0, 16'd2);
                add_name(NAME_ROOT);
                add_rr(16'd28, 16'd1, 32'd300, 16'd2);
                add_name(NAME_PTR);
                add_rr(16'd16, 16'd1, 32'd7, 16'd6);
                repeat (3) put_byte(rnd8());
            end
            DK_TRUNC: begin
                add_header(cur_id, 8'h00, 16'd0, 16'd2);
                add_name(NAME_ROOT);
                add_rr(16'd1, 16'd1, 32'd1, 16'd1);
                add_name(NAME_LABELS);
                add_rr(16'd1, 16'd1, 32'd1, 16'd8);
                cut_to(pkt.size() - 5);
            end
            DK_MIDID: begin
                add_header(cur_id, 8'h00, 16'd0, 16'd1);
                add_name(NAME_ROOT);
                add_rr(16'd5, 16'd1, 32'd9, 16'd3);
                split_at = dnsap_pkg::HeaderLen - 1;
                split_id = cur_id ^ 16'h8001;
            end
            default: begin
                // longest label in the question, then padding past the size limit
                add_header(cur_id, 8'h00, 16'd1, 16'd1);
                add_name(NAME_BIGLABEL);
                repeat (4) put_byte(rnd8());
                add_name(NAME_PTR);
                add_rr(16'd1, 16'd1, 32'd2, 16'd5);
                pad_to(dnsap_pkg::MaxPacketBytes + 8);
            end
        endcase
    endtask

    task automatic build_random();
        int          r, nq, na;
        logic [15:0] qd, an;
        pkt.delete();
        split_at = -1;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            repeat ($urandom_range(1, dnsap_pkg::HeaderLen - 1)) put_byte(rnd8());
        end else if (r < 16) begin
            repeat ($urandom_range(dnsap_pkg::HeaderLen, 48)) put_byte(rnd8());
            if ($urandom_range(0, 1) == 0) begin
                pkt[0] = cur_id[15:8];
                pkt[1] = cur_id[7:0];
            end
        end else begin
            nq = $urandom_range(0, 2);
            na = $urandom_range(0, 3);
            qd = 16'(nq);
            an = 16'(na);
            if ($urandom_range(0, 19) == 0) qd = 16'hFFFF;
            if ($urandom_range(0, 19) == 0) an = 16'($urandom);
            if (r < 26) begin
                if ($urandom_range(0, 1) == 0)
                    add_header(cur_id ^ 16'($urandom_range(1, 65535)), rnd8(), qd, an);
                else
                    add_header(cur_id, 8'($urandom_range(1, 15)) | (rnd8() & 8'hF0), qd, an);
            end else begin
                add_header(cur_id, rnd8() & 8'hF0, qd, an);
            end
            add_body(nq, na);
            r = $urandom_range(0, 99);
            if (r < 15 && pkt.size() > 1) cut_to($urandom_range(1, pkt.size() - 1));
            else if (r < 30) repeat ($urandom_range(1, 8)) put_byte(rnd8());
        end
    endtask

    // ---------------- driving ----------------

    task automatic write_id(input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_id = v;
    endtask

    // drain outstanding results and let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        bit hit;
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        do begin
            @(negedge i_clk);
            hit = s_axis_tready;
            @(posedge i_clk);
        end while (!hit);
        bytes_sent++;
        track_byte(b, lst);
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
            if (i == split_at) begin
                settle();
                write_id(split_id);
            end
        end
    endtask

    // ---------------- sink and checking ----------------

    int sink_hold = 0;
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) sink_hold <= pick_gap();
        end
    end

    task automatic cmp(input string f, input logic [31:0] w, input logic [31:0] g);
        if (w !== g) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, f, w, g);
        end
    endtask

    always @(negedge i_clk) begin : check_out
        t_parse_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual kind %0b data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = due.pop_front();
                cmp("kind", 32'(want.kind), 32'(m_axis_tuser));
                cmp("rec_type", 32'(want.rtype), 32'(m_axis_tdata[15:0]));
                cmp("rec_class", 32'(want.rclass), 32'(m_axis_tdata[31:16]));
                cmp("time_to_live", want.ttl, m_axis_tdata[63:32]);
                cmp("data_length", 32'(want.dlen), 32'(m_axis_tdata[79:64]));
                cmp("data_head", want.head, m_axis_tdata[111:80]);
                cmp("status", 32'(want.status), 32'(m_axis_tdata[114:112]));
                cmp("answer_count", 32'(want.count), 32'(m_axis_tdata[130:115]));
                cmp("packet_done", 32'(want.done), 32'(m_axis_tlast));
            end
        end
    end

    // ---------------- stimulus ----------------

    t_drow plan [12];

    initial begin
        plan = '{
            '{1'b0, 16'h0000, DK_SHORT,   1'b1, dnsap_pkg::StShort,  16'd0},
            '{1'b0, 16'h0000, DK_EMPTY,   1'b1, dnsap_pkg::StOk,     16'd0},
            '{1'b1, 16'hFFFF, DK_SHORT11, 1'b1, dnsap_pkg::StShort,  16'd0},
            '{1'b0, 16'h0000, DK_BADID,   1'b1, dnsap_pkg::StIdMis,  16'd0},
            '{1'b0, 16'h0000, DK_RCODE,   1'b1, dnsap_pkg::StRcode,  16'd0},
            '{1'b0, 16'h0000, DK_BOTH,    1'b1, dnsap_pkg::StIdMis,  16'd0},
            '{1'b1, 16'h0000, DK_PTR,     1'b0, dnsap_pkg::StOk,     16'd0},
            '{1'b1, 16'h1234, DK_LABELS,  1'b0, dnsap_pkg::StOk,     16'd0},
            '{1'b0, 16'h0000, DK_PAD,     1'b0, dnsap_pkg::StOk,     16'd0},
            '{1'b0, 16'h0000, DK_TRUNC,   1'b0, dnsap_pkg::StOk,     16'd0},
            '{1'b1, 16'hFFFF, DK_MIDID,   1'b0, dnsap_pkg::StOk,     16'd0},
            '{1'b0, 16'h0000, DK_OVER,    1'b0, dnsap_pkg::StOk,     16'd0}
        };
        restart_packet();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].cfg_we) write_id(plan[i].cfg_val);
            build_directed(plan[i].what);
            typed_on = plan[i].typed;
            typed_st = plan[i].st;
            typed_cnt = plan[i].cnt;
            send_packet();
            settle();
            typed_on = 1'b0;
        end

        while (bytes_sent < 1000) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) begin
                settle();
                case ($urandom_range(0, 3))
                    0: write_id(16'h0000);
                    1: write_id(16'hFFFF);
                    default: write_id(16'($urandom));
                endcase
            end
            build_random();
            send_packet();
        end

        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_dns_response_answer_parser_unit: done, clean");
        end else begin
            $display("tb_dns_response_answer_parser_unit: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
design/dnsap_pkg.sv
design/dnsap_front.sv
design/dnsap_fifo.sv
design/dnsap_back.sv
design/dns_response_answer_parser_unit.sv
sim/tb_dns_response_answer_parser_unit.sv
